FILE: src/trimmed_mean_delta_smoother_top_defines.svh
// Assertion macros for the trimmed mean delta smoother.
`ifndef TRIMMED_MEAN_DELTA_SMOOTHER_TOP_DEFINES_SVH
`define TRIMMED_MEAN_DELTA_SMOOTHER_TOP_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define TMDS_ASSERT_IMPLIES(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tmds assertion failed");

// next-cycle implication
`define TMDS_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tmds assertion failed");

`endif

FILE: src/tmds_pkg.sv
// Shared constants and types of the trimmed mean delta smoother.
package tmds_pkg;

	localparam int DELTA_W        = 24;
	localparam int GAIN_W         = 16;
	localparam int OUT_W          = 32;
	localparam int FRAC_W         = 8;
	localparam int WINDOW_LEN     = 11;
	localparam int TRIM_EACH_SIDE = 2;
	localparam int TRIM_USED      = (2 * TRIM_EACH_SIDE < WINDOW_LEN) ?
	                                TRIM_EACH_SIDE : (WINDOW_LEN - 1) / 2;
	localparam int KEPT           = WINDOW_LEN - 2 * TRIM_USED;
	localparam int SUM_W          = DELTA_W + $clog2(KEPT + 1);
	localparam int NUM_W          = SUM_W + FRAC_W;
	localparam int REM_W          = $clog2(KEPT + 1);
	localparam int CNT_W          = $clog2(WINDOW_LEN);
	localparam int PROD_W         = OUT_W + GAIN_W + 1;

	// reciprocal of KEPT, rounded up; gives the exact floor for any SUM_W-bit sum
	localparam int RECIP_SH       = SUM_W + $clog2(KEPT);
	localparam int RECIP_W        = SUM_W + 1;
	localparam int QPROD_W        = RECIP_SH + SUM_W;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << RECIP_SH) + 64'(KEPT - 1)) / 64'(KEPT));

	localparam logic [DELTA_W-1:0] IDEAL_DELTA = DELTA_W'(16670);
	localparam logic [OUT_W-1:0]   AVG_RESET   = OUT_W'(16670 * 256);
	localparam logic [GAIN_W-1:0]  GAIN_RESET  = GAIN_W'(6554);

	// per-cycle command to every cell of the ranking chain
	typedef struct packed {
		logic clr;
		logic ins;
		logic shf;
	} cell_ctl_t;

endpackage

FILE: src/tmds_channels.sv
// Valid/ready channel interfaces for the sample input and result output.
interface tmds_in_if;
	logic                         valid;
	logic                         ready;
	logic [tmds_pkg::DELTA_W-1:0] delta_us;

	modport source (output valid, output delta_us, input ready);
	modport sink (input valid, input delta_us, output ready);
endinterface

interface tmds_out_if;
	logic                       valid;
	logic                       ready;
	logic [tmds_pkg::OUT_W-1:0] smoothed_delta;

	modport source (output valid, output smoothed_delta, input ready);
	modport sink (input valid, input smoothed_delta, output ready);
endinterface

FILE: src/tmds_cell.sv
// One cell of the insertion ranking chain: keeps the smaller value, passes the larger.
module tmds_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tmds_pkg::cell_ctl_t          ctl,
	input  logic [tmds_pkg::DELTA_W-1:0] prev_pass_val,
	input  logic                         prev_pass_vld,
	input  logic [tmds_pkg::DELTA_W-1:0] prev_hold,
	output logic [tmds_pkg::DELTA_W-1:0] pass_val,
	output logic                         pass_vld,
	output logic [tmds_pkg::DELTA_W-1:0] hold,
	output logic                         full
);

	logic [tmds_pkg::DELTA_W-1:0] val_q;
	logic [tmds_pkg::DELTA_W-1:0] pass_val_q;
	logic                         pass_vld_q;
	logic                         full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q     <= 1'b0;
			pass_vld_q <= 1'b0;
		end else if (ctl.clr) begin
			full_q     <= 1'b0;
			pass_vld_q <= 1'b0;
		end else if (ctl.ins) begin
			if (prev_pass_vld) begin
				full_q <= 1'b1;
			end
			pass_vld_q <= prev_pass_vld && full_q;
		end else begin
			pass_vld_q <= 1'b0;
		end
	end

	// payload: no reset
	always_ff @(posedge clk) begin
		if (ctl.ins && prev_pass_vld) begin
			if (!full_q) begin
				val_q <= prev_pass_val;
			end else if (prev_pass_val < val_q) begin
				val_q      <= prev_pass_val;
				pass_val_q <= val_q;
			end else begin
				pass_val_q <= prev_pass_val;
			end
		end else if (ctl.shf) begin
			val_q <= prev_hold;
		end
	end

	assign pass_val = pass_val_q;
	assign pass_vld = pass_vld_q;
	assign hold     = val_q;
	assign full     = full_q;

endmodule

FILE: src/trimmed_mean_delta_smoother_top.sv
// Top level: sample window, ranking chain, trimmed sum, divider and smoothing blend.
// One item at a time: din.ready is high only in ST_IDLE, so no new beat is taken until
// the last result has been loaded into the output register. Each beat runs three
// passes over the cell chain, one reciprocal divide, two blend steps and the load.
// A finished result waits in the output register while the next beat is accepted.
// Reset (arst_n low, async): window all 16670, average 16670 in Q24.8, gain 6554.
`include "trimmed_mean_delta_smoother_top_defines.svh"

module trimmed_mean_delta_smoother_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [tmds_pkg::GAIN_W-1:0] cfg_wr_data,
	tmds_in_if.sink                     din,
	tmds_out_if.source                  dout
);

	localparam int N = tmds_pkg::WINDOW_LEN;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FEED,   // rotate window into the ranking chain
		ST_DRAIN,  // let passed values settle into their cells
		ST_SUM,    // shift ranked values out, largest first, sum the kept ones
		ST_DIV,    // quotient of the sum by the kept count, reciprocal multiply
		ST_BL1,    // avg * (1 - gain); remainder picks the mean's fraction bits
		ST_BL2,    // + mean * gain, round
		ST_FIN     // hand result to the output register
	} state_t;

	state_t                        state_q;
	logic [tmds_pkg::CNT_W-1:0]    cnt_q;
	logic [tmds_pkg::DELTA_W-1:0]  win_q [N];
	logic [tmds_pkg::SUM_W-1:0]    acc_q;
	logic [tmds_pkg::SUM_W-1:0]    quot_q;
	logic [tmds_pkg::NUM_W-1:0]    num_q;
	logic [tmds_pkg::PROD_W-1:0]   prod_q;
	logic [tmds_pkg::OUT_W-1:0]    avg_q;
	logic [tmds_pkg::GAIN_W-1:0]   gain_q;
	logic [tmds_pkg::OUT_W-1:0]    out_q;
	logic                          out_vld_q;

	// chain wiring
	tmds_pkg::cell_ctl_t           cell_ctl;
	logic [tmds_pkg::DELTA_W-1:0]  pass_val [N];
	logic                          pass_vld [N];
	logic [tmds_pkg::DELTA_W-1:0]  hold_val [N];
	logic [N-1:0]                  cell_full;

	logic                          in_beat;
	logic                          cnt_last;
	logic                          kept_pos;
	logic [tmds_pkg::SUM_W-1:0]    acc_next;
	logic [tmds_pkg::QPROD_W-1:0]  qprod;
	logic [tmds_pkg::SUM_W-1:0]    rem_full;
	logic [tmds_pkg::REM_W-1:0]    rem_lo;
	logic [tmds_pkg::FRAC_W-1:0]   mean_frac;
	logic [tmds_pkg::GAIN_W:0]     inv_gain;
	logic [tmds_pkg::PROD_W-1:0]   blend;
	logic                          out_free;
	logic                          out_load;

	assign din.ready = (state_q == ST_IDLE);
	assign in_beat   = din.valid && din.ready;
	assign out_free  = !out_vld_q || dout.ready;
	assign out_load  = (state_q == ST_FIN) && out_free;
	assign cnt_last  = (cnt_q == tmds_pkg::CNT_W'(N - 1));

	assign cell_ctl.clr = in_beat;
	assign cell_ctl.ins = (state_q == ST_FEED) || (state_q == ST_DRAIN);
	assign cell_ctl.shf = (state_q == ST_SUM);

	generate
		for (genvar i = 0; i < N; i++) begin : g_cell
			if (i == 0) begin : g_head
				tmds_cell u_cell (
					.clk          (clk),
					.arst_n       (arst_n),
					.ctl          (cell_ctl),
					.prev_pass_val(win_q[N-1]),
					.prev_pass_vld(state_q == ST_FEED),
					.prev_hold    ('0),
					.pass_val     (pass_val[i]),
					.pass_vld     (pass_vld[i]),
					.hold         (hold_val[i]),
					.full         (cell_full[i])
				);
			end else begin : g_body
				tmds_cell u_cell (
					.clk          (clk),
					.arst_n       (arst_n),
					.ctl          (cell_ctl),
					.prev_pass_val(pass_val[i-1]),
					.prev_pass_vld(pass_vld[i-1]),
					.prev_hold    (hold_val[i-1]),
					.pass_val     (pass_val[i]),
					.pass_vld     (pass_vld[i]),
					.hold         (hold_val[i]),
					.full         (cell_full[i])
				);
			end
		end
	endgenerate

	// last cell holds the cnt_q-th largest sample during the shift-out
	assign kept_pos = (cnt_q >= tmds_pkg::CNT_W'(tmds_pkg::TRIM_USED)) &&
	                  (cnt_q < tmds_pkg::CNT_W'(N - tmds_pkg::TRIM_USED));
	assign acc_next = kept_pos ? acc_q + tmds_pkg::SUM_W'(hold_val[N-1]) : acc_q;

	// sum / KEPT: rounded-up reciprocal, exact floor over the whole sum range
	assign qprod    = tmds_pkg::QPROD_W'(acc_q) * tmds_pkg::QPROD_W'(tmds_pkg::RECIP);
	assign rem_full = acc_q - quot_q * tmds_pkg::SUM_W'(tmds_pkg::KEPT);
	assign rem_lo   = rem_full[tmds_pkg::REM_W-1:0];

	// fraction bits of the mean: (rem * 256 + KEPT / 2) / KEPT, a small constant table
	always_comb begin
		mean_frac = '0;
		for (int b = 0; b < tmds_pkg::KEPT; b++) begin
			if (rem_lo == tmds_pkg::REM_W'(b)) begin
				mean_frac = tmds_pkg::FRAC_W'((b * (1 << tmds_pkg::FRAC_W) +
				            tmds_pkg::KEPT / 2) / tmds_pkg::KEPT);
			end
		end
	end

	assign inv_gain = (tmds_pkg::GAIN_W+1)'(1 << tmds_pkg::GAIN_W) - {1'b0, gain_q};
	assign blend    = prod_q
	                + tmds_pkg::PROD_W'(num_q[tmds_pkg::OUT_W-1:0]) * tmds_pkg::PROD_W'(gain_q)
	                + tmds_pkg::PROD_W'(1 << (tmds_pkg::GAIN_W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			for (int i = 0; i < N; i++) begin
				win_q[i] <= tmds_pkg::IDEAL_DELTA;
			end
			avg_q     <= tmds_pkg::AVG_RESET;
			gain_q    <= tmds_pkg::GAIN_RESET;
			out_vld_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				gain_q <= cfg_wr_data;
			end
			// a load in the same cycle keeps valid high
			if (dout.valid && dout.ready && !out_load) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						// newest in at slot 0, oldest drops off the end
						win_q[0] <= din.delta_us;
						for (int i = 1; i < N; i++) begin
							win_q[i] <= win_q[i-1];
						end
						cnt_q   <= '0;
						state_q <= ST_FEED;
					end
				end
				ST_FEED: begin
					// full rotation leaves the window as it was
					win_q[0] <= win_q[N-1];
					for (int i = 1; i < N; i++) begin
						win_q[i] <= win_q[i-1];
					end
					cnt_q <= cnt_last ? '0 : cnt_q + 1'b1;
					if (cnt_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					cnt_q <= cnt_last ? '0 : cnt_q + 1'b1;
					if (cnt_last) begin
						acc_q   <= '0;
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					acc_q <= acc_next;
					cnt_q <= cnt_last ? '0 : cnt_q + 1'b1;
					if (cnt_last) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					quot_q  <= qprod[tmds_pkg::RECIP_SH +: tmds_pkg::SUM_W];
					state_q <= ST_BL1;
				end
				ST_BL1: begin
					prod_q  <= tmds_pkg::PROD_W'(avg_q) * tmds_pkg::PROD_W'(inv_gain);
					num_q   <= {quot_q, mean_frac};
					state_q <= ST_BL2;
				end
				ST_BL2: begin
					avg_q   <= blend[tmds_pkg::GAIN_W +: tmds_pkg::OUT_W];
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						out_q     <= avg_q;
						out_vld_q <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign dout.valid          = out_vld_q;
	assign dout.smoothed_delta = out_q;

	// every cell must have settled before the shift-out starts
	`TMDS_ASSERT_IMPLIES(a_chain_full_at_sum, (state_q == ST_SUM) && (cnt_q == '0), &cell_full)
	// reciprocal quotient leaves a remainder below the divisor
	`TMDS_ASSERT_IMPLIES(a_rem_bound, state_q == ST_BL1, rem_full < tmds_pkg::SUM_W'(tmds_pkg::KEPT))
	// an accepted beat starts a fresh feed pass
	`TMDS_ASSERT_NEXT(a_beat_starts_feed, in_beat, (state_q == ST_FEED) && (cnt_q == '0))
	// a finished average lands in the output register
	`TMDS_ASSERT_NEXT(a_result_loaded, (state_q == ST_FIN) && out_free, dout.valid && (dout.smoothed_delta == $past(avg_q)))

endmodule
